// ----- rtl/assert_macros.svh -----
// ============================================================================
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk and disabled in reset.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising edge of clk outside reset.
`define RTI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define RTI_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/rti_pkg.sv -----
// ============================================================================
// Ray-triangle intersection package
// Widths, register indexes, payload types and fixed-point helpers.
// ============================================================================
`timescale 1ns / 1ps

package rti_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int Q_W         = 32;
    localparam int PROD_W      = 2 * Q_W;
    localparam int FLR_W       = PROD_W - FRAC_BITS;
    localparam int NUM_W       = FLR_W + 2;
    localparam int QUO_W       = Q_W - 1;
    localparam int DIV_W       = NUM_W + QUO_W;
    localparam int SAT_SHIFT   = QUO_W - FRAC_BITS;
    localparam int PROJ_W      = FLR_W + 2;
    localparam int BG_W        = FLR_W + 1;
    localparam int ONE_Q       = 1 << FRAC_BITS;
    localparam int CFG_W       = 64;
    localparam int CFG_ADDR_W  = 3;
    localparam int CLAMP_W     = (COORD_WIDTH > Q_W) ? COORD_WIDTH : Q_W + 1;

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_AXIS,
        CFG_SLOPES,
        CFG_OFFSET,
        CFG_BETA,
        CFG_GAMMA,
        CFG_ANCHOR
    } cfg_reg_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] origin_x;
        logic signed [COORD_WIDTH-1:0] origin_y;
        logic signed [COORD_WIDTH-1:0] origin_z;
        logic signed [COORD_WIDTH-1:0] dir_x;
        logic signed [COORD_WIDTH-1:0] dir_y;
        logic signed [COORD_WIDTH-1:0] dir_z;
        logic signed [COORD_WIDTH-1:0] t_min;
        logic signed [COORD_WIDTH-1:0] t_max;
    } ray_t;

    typedef struct packed {
        logic                  hit;
        logic signed [Q_W-1:0] hit_distance;
    } hit_t;

    // Brings an input coordinate of any width to a saturated Q16.16 value.
    function automatic logic signed [Q_W-1:0] coord_clamp(
        input logic signed [COORD_WIDTH-1:0] v
    );
        logic signed [CLAMP_W-1:0] w;
        w = CLAMP_W'(v);
        if (w > CLAMP_W'(Q_MAX)) begin
            return Q_MAX;
        end
        if (w < CLAMP_W'(Q_MIN)) begin
            return Q_MIN;
        end
        return w[Q_W-1:0];
    endfunction

    // Drops the fraction of a full product, rounding toward minus infinity.
    function automatic logic signed [FLR_W-1:0] floor_q(
        input logic signed [PROD_W-1:0] p
    );
        return p[PROD_W-1:FRAC_BITS];
    endfunction

    // Saturates a projection sum to Q16.16.
    function automatic logic signed [Q_W-1:0] sat_q(
        input logic signed [PROJ_W-1:0] x
    );
        if (x > PROJ_W'(Q_MAX)) begin
            return Q_MAX;
        end
        if (x < PROJ_W'(Q_MIN)) begin
            return Q_MIN;
        end
        return x[Q_W-1:0];
    endfunction

endpackage

// ----- rtl/ray_triangle_intersect_core.sv -----
// ============================================================================
// Ray-triangle intersection core
// Fully pipelined projection-method ray/triangle test in signed Q16.16.
// ============================================================================
// Usage: the block takes one ray transaction per clock while busy is low and
// returns one result transaction per ray, in order. The hit distance is
// formed by a restoring divider unrolled into 31 pipeline stages, one
// quotient bit per stage, wrapped by five stages in front (input capture,
// plane products, numerator and denominator sums, magnitudes, overflow check)
// and six behind (distance, distance products, projection, barycentric
// products, barycentric sums, result). A transaction is accepted when start
// is high and busy is low; busy is high only in reset and the cycle after
// it. Results appear on result for one cycle with done high, and the
// receiver cannot hold them off, so it must take every done cycle. The
// triangle registers are written through cfg_we/cfg_addr/cfg_wdata and must
// only change while no ray is in flight.
// ============================================================================
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ray_triangle_intersect_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  rti_pkg::ray_t                       ray,
    output logic                                done,
    output rti_pkg::hit_t                       result,
    input  logic                                cfg_we,
    input  logic [rti_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [rti_pkg::CFG_W-1:0]           cfg_wdata
);

    localparam int Q_W       = rti_pkg::Q_W;
    localparam int PROD_W    = rti_pkg::PROD_W;
    localparam int NUM_W     = rti_pkg::NUM_W;
    localparam int DIV_W     = rti_pkg::DIV_W;
    localparam int QUO_W     = rti_pkg::QUO_W;
    localparam int PROJ_W    = rti_pkg::PROJ_W;
    localparam int BG_W      = rti_pkg::BG_W;
    localparam int DIV_STEPS = QUO_W;
    localparam int LATENCY   = DIV_STEPS + 11;

    localparam logic signed [BG_W:0] BG_ONE = (BG_W+1)'(rti_pkg::ONE_Q);

    // Ray terms in the triangle's (n, u, v) frame.
    typedef struct packed {
        logic signed [Q_W-1:0] on;
        logic signed [Q_W-1:0] ou;
        logic signed [Q_W-1:0] ov;
        logic signed [Q_W-1:0] dn;
        logic signed [Q_W-1:0] du;
        logic signed [Q_W-1:0] dv;
        logic signed [Q_W-1:0] t_lo;
        logic signed [Q_W-1:0] t_hi;
    } geo_t;

    // Terms still needed once the plane distance has been set up.
    typedef struct packed {
        logic signed [Q_W-1:0] ou;
        logic signed [Q_W-1:0] ov;
        logic signed [Q_W-1:0] du;
        logic signed [Q_W-1:0] dv;
        logic signed [Q_W-1:0] t_lo;
        logic signed [Q_W-1:0] t_hi;
    } side_t;

    typedef struct packed {
        side_t             side;
        logic              zero;
        logic              neg;
        logic              sat;
        logic [DIV_W-1:0]  rem;
        logic [NUM_W-1:0]  b;
        logic [QUO_W-1:0]  q;
    } div_t;

    // ------------------------------------------------------------------
    // Triangle registers
    // ------------------------------------------------------------------
    logic [1:0]                 axis_reg;
    logic [rti_pkg::CFG_W-1:0]  slopes_reg;
    logic signed [Q_W-1:0]      offset_reg;
    logic [rti_pkg::CFG_W-1:0]  beta_reg;
    logic [rti_pkg::CFG_W-1:0]  gamma_reg;
    logic [rti_pkg::CFG_W-1:0]  anchor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg   <= '0;
            slopes_reg <= '0;
            offset_reg <= '0;
            beta_reg   <= '0;
            gamma_reg  <= '0;
            anchor_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                rti_pkg::CFG_AXIS:   axis_reg   <= cfg_wdata[1:0];
                rti_pkg::CFG_SLOPES: slopes_reg <= cfg_wdata;
                rti_pkg::CFG_OFFSET: offset_reg <= cfg_wdata[Q_W-1:0];
                rti_pkg::CFG_BETA:   beta_reg   <= cfg_wdata;
                rti_pkg::CFG_GAMMA:  gamma_reg  <= cfg_wdata;
                rti_pkg::CFG_ANCHOR: anchor_reg <= cfg_wdata;
                default:             ;
            endcase
        end
    end

    logic signed [Q_W-1:0] su, sv;
    logic signed [Q_W-1:0] beta_v, beta_u, gamma_u, gamma_v;
    logic signed [Q_W-1:0] anchor_u, anchor_v;

    assign su       = slopes_reg[Q_W-1:0];
    assign sv       = slopes_reg[2*Q_W-1:Q_W];
    assign beta_v   = beta_reg[Q_W-1:0];
    assign beta_u   = beta_reg[2*Q_W-1:Q_W];
    assign gamma_u  = gamma_reg[Q_W-1:0];
    assign gamma_v  = gamma_reg[2*Q_W-1:Q_W];
    assign anchor_u = anchor_reg[Q_W-1:0];
    assign anchor_v = anchor_reg[2*Q_W-1:Q_W];

    // ------------------------------------------------------------------
    // Handshake: the pipeline never stalls, so busy only covers reset.
    // ------------------------------------------------------------------
    logic busy_reg;
    logic accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    assign busy   = busy_reg;
    assign accept = start && !busy_reg;

    // ------------------------------------------------------------------
    // Stage 0: clamp coordinates and rotate them into the (n, u, v) frame.
    // An axis code of three behaves like the x axis.
    // ------------------------------------------------------------------
    logic signed [Q_W-1:0] ox, oy, oz, dx, dy, dz;
    geo_t geo_next;
    logic s0_vld_reg;
    geo_t s0_geo_reg;

    always_comb
    begin
        ox = rti_pkg::coord_clamp(ray.origin_x);
        oy = rti_pkg::coord_clamp(ray.origin_y);
        oz = rti_pkg::coord_clamp(ray.origin_z);
        dx = rti_pkg::coord_clamp(ray.dir_x);
        dy = rti_pkg::coord_clamp(ray.dir_y);
        dz = rti_pkg::coord_clamp(ray.dir_z);
        geo_next.t_lo = rti_pkg::coord_clamp(ray.t_min);
        geo_next.t_hi = rti_pkg::coord_clamp(ray.t_max);
        case (axis_reg)
            rti_pkg::AXIS_Y:
            begin
                geo_next.on = oy; geo_next.ou = oz; geo_next.ov = ox;
                geo_next.dn = dy; geo_next.du = dz; geo_next.dv = dx;
            end
            rti_pkg::AXIS_Z:
            begin
                geo_next.on = oz; geo_next.ou = ox; geo_next.ov = oy;
                geo_next.dn = dz; geo_next.du = dx; geo_next.dv = dy;
            end
            default:
            begin
                geo_next.on = ox; geo_next.ou = oy; geo_next.ov = oz;
                geo_next.dn = dx; geo_next.du = dy; geo_next.dv = dz;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
        end
        else
        begin
            s0_vld_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_geo_reg <= geo_next;
    end

    // ------------------------------------------------------------------
    // Stage 1: the four slope products of the plane equation.
    // ------------------------------------------------------------------
    logic s1_vld_reg;
    side_t s1_side_reg;
    logic signed [Q_W-1:0] s1_on_reg, s1_dn_reg;
    logic signed [PROD_W-1:0] s1_pdu_reg, s1_pdv_reg, s1_pou_reg, s1_pov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s0_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_side_reg.ou   <= s0_geo_reg.ou;
        s1_side_reg.ov   <= s0_geo_reg.ov;
        s1_side_reg.du   <= s0_geo_reg.du;
        s1_side_reg.dv   <= s0_geo_reg.dv;
        s1_side_reg.t_lo <= s0_geo_reg.t_lo;
        s1_side_reg.t_hi <= s0_geo_reg.t_hi;
        s1_on_reg        <= s0_geo_reg.on;
        s1_dn_reg        <= s0_geo_reg.dn;
        s1_pdu_reg       <= su * s0_geo_reg.du;
        s1_pdv_reg       <= sv * s0_geo_reg.dv;
        s1_pou_reg       <= su * s0_geo_reg.ou;
        s1_pov_reg       <= sv * s0_geo_reg.ov;
    end

    // ------------------------------------------------------------------
    // Stage 2: denominator and numerator of the plane distance.
    // ------------------------------------------------------------------
    logic s2_vld_reg;
    side_t s2_side_reg;
    logic signed [NUM_W-1:0] s2_den_reg, s2_num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_side_reg <= s1_side_reg;
        s2_den_reg  <= NUM_W'(s1_dn_reg)
                     + NUM_W'(rti_pkg::floor_q(s1_pdu_reg))
                     + NUM_W'(rti_pkg::floor_q(s1_pdv_reg));
        s2_num_reg  <= NUM_W'(offset_reg)
                     - (NUM_W'(s1_on_reg)
                        + NUM_W'(rti_pkg::floor_q(s1_pou_reg))
                        + NUM_W'(rti_pkg::floor_q(s1_pov_reg)));
    end

    // ------------------------------------------------------------------
    // Stage 3: magnitudes and sign for the unsigned divider.
    // ------------------------------------------------------------------
    logic s3_vld_reg;
    side_t s3_side_reg;
    logic [NUM_W-1:0] s3_a_reg, s3_b_reg;
    logic s3_neg_reg, s3_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_side_reg <= s2_side_reg;
        s3_a_reg    <= s2_num_reg[NUM_W-1] ? -s2_num_reg : s2_num_reg;
        s3_b_reg    <= s2_den_reg[NUM_W-1] ? -s2_den_reg : s2_den_reg;
        s3_neg_reg  <= s2_num_reg[NUM_W-1] ^ s2_den_reg[NUM_W-1];
        s3_zero_reg <= (s2_den_reg == '0);
    end

    // ------------------------------------------------------------------
    // Divider: stage 0 checks whether the integer part overflows Q16.16
    // and loads the scaled numerator; each later stage settles one
    // quotient bit, most significant first.
    // ------------------------------------------------------------------
    logic div_vld_reg [0:DIV_STEPS];
    div_t div_reg     [0:DIV_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_vld_reg[0] <= 1'b0;
        end
        else
        begin
            div_vld_reg[0] <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg[0].side <= s3_side_reg;
        div_reg[0].zero <= s3_zero_reg;
        div_reg[0].neg  <= s3_neg_reg;
        div_reg[0].sat  <= DIV_W'(s3_a_reg) >= (DIV_W'(s3_b_reg) << rti_pkg::SAT_SHIFT);
        div_reg[0].rem  <= DIV_W'(s3_a_reg) << rti_pkg::FRAC_BITS;
        div_reg[0].b    <= s3_b_reg;
        div_reg[0].q    <= '0;
    end

    for (genvar k = 1; k <= DIV_STEPS; k++)
    begin : g_div
        localparam int BIT = DIV_STEPS - k;
        logic [DIV_W-1:0] trial;
        div_t div_next;

        assign trial = DIV_W'(div_reg[k-1].b) << BIT;

        always_comb
        begin
            div_next = div_reg[k-1];
            if (div_reg[k-1].rem >= trial)
            begin
                div_next.rem    = div_reg[k-1].rem - trial;
                div_next.q[BIT] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_vld_reg[k] <= 1'b0;
            end
            else
            begin
                div_vld_reg[k] <= div_vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            div_reg[k] <= div_next;
        end
    end

    // ------------------------------------------------------------------
    // Distance stage: signed, saturated t.
    // ------------------------------------------------------------------
    logic signed [Q_W-1:0] q_signed;
    logic signed [Q_W-1:0] t_next;
    logic t_vld_reg, t_zero_reg;
    logic signed [Q_W-1:0] t_reg;
    side_t t_side_reg;

    always_comb
    begin
        q_signed = {1'b0, div_reg[DIV_STEPS].q};
        if (div_reg[DIV_STEPS].sat)
        begin
            t_next = div_reg[DIV_STEPS].neg ? rti_pkg::Q_MIN : rti_pkg::Q_MAX;
        end
        else
        begin
            t_next = div_reg[DIV_STEPS].neg ? -q_signed : q_signed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_vld_reg <= 1'b0;
        end
        else
        begin
            t_vld_reg <= div_vld_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg      <= t_next;
        t_side_reg <= div_reg[DIV_STEPS].side;
        t_zero_reg <= div_reg[DIV_STEPS].zero;
    end

    // ------------------------------------------------------------------
    // Distance products and the interval check.
    // ------------------------------------------------------------------
    logic m_vld_reg, m_ivok_reg, m_zero_reg;
    logic signed [Q_W-1:0] m_t_reg, m_ou_reg, m_ov_reg;
    logic signed [PROD_W-1:0] m_tdu_reg, m_tdv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
        end
        else
        begin
            m_vld_reg <= t_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m_t_reg    <= t_reg;
        m_ou_reg   <= t_side_reg.ou;
        m_ov_reg   <= t_side_reg.ov;
        m_tdu_reg  <= t_reg * t_side_reg.du;
        m_tdv_reg  <= t_reg * t_side_reg.dv;
        m_ivok_reg <= (t_reg >= t_side_reg.t_lo) && (t_reg <= t_side_reg.t_hi);
        m_zero_reg <= t_zero_reg;
    end

    // ------------------------------------------------------------------
    // Hit point projected onto (u, v), relative to the first vertex.
    // ------------------------------------------------------------------
    logic p_vld_reg, p_ivok_reg, p_zero_reg;
    logic signed [Q_W-1:0] p_t_reg, p_pu_reg, p_pv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
        end
        else
        begin
            p_vld_reg <= m_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_t_reg    <= m_t_reg;
        p_pu_reg   <= rti_pkg::sat_q(PROJ_W'(m_ou_reg)
                                     + PROJ_W'(rti_pkg::floor_q(m_tdu_reg))
                                     - PROJ_W'(anchor_u));
        p_pv_reg   <= rti_pkg::sat_q(PROJ_W'(m_ov_reg)
                                     + PROJ_W'(rti_pkg::floor_q(m_tdv_reg))
                                     - PROJ_W'(anchor_v));
        p_ivok_reg <= m_ivok_reg;
        p_zero_reg <= m_zero_reg;
    end

    // ------------------------------------------------------------------
    // Barycentric weight products.
    // ------------------------------------------------------------------
    logic w_vld_reg, w_ivok_reg, w_zero_reg;
    logic signed [Q_W-1:0] w_t_reg;
    logic signed [PROD_W-1:0] w_bv_reg, w_bu_reg, w_gu_reg, w_gv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_vld_reg <= 1'b0;
        end
        else
        begin
            w_vld_reg <= p_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        w_t_reg    <= p_t_reg;
        w_bv_reg   <= p_pv_reg * beta_v;
        w_bu_reg   <= p_pu_reg * beta_u;
        w_gu_reg   <= p_pu_reg * gamma_u;
        w_gv_reg   <= p_pv_reg * gamma_v;
        w_ivok_reg <= p_ivok_reg;
        w_zero_reg <= p_zero_reg;
    end

    // ------------------------------------------------------------------
    // Barycentric coordinates beta and gamma.
    // ------------------------------------------------------------------
    logic b_vld_reg, b_ivok_reg, b_zero_reg;
    logic signed [Q_W-1:0] b_t_reg;
    logic signed [BG_W-1:0] b_beta_reg, b_gamma_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else
        begin
            b_vld_reg <= w_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_t_reg     <= w_t_reg;
        b_beta_reg  <= BG_W'(rti_pkg::floor_q(w_bv_reg)) + BG_W'(rti_pkg::floor_q(w_bu_reg));
        b_gamma_reg <= BG_W'(rti_pkg::floor_q(w_gu_reg)) + BG_W'(rti_pkg::floor_q(w_gv_reg));
        b_ivok_reg  <= w_ivok_reg;
        b_zero_reg  <= w_zero_reg;
    end

    // ------------------------------------------------------------------
    // Result: a hit needs a non-parallel ray, t inside the interval and the
    // point inside the triangle. A miss reports distance zero.
    // ------------------------------------------------------------------
    logic signed [BG_W:0] bg_sum;
    logic hit_next;
    logic done_reg;
    rti_pkg::hit_t result_reg;

    always_comb
    begin
        bg_sum   = (BG_W+1)'(b_beta_reg) + (BG_W+1)'(b_gamma_reg);
        hit_next = !b_zero_reg && b_ivok_reg && !b_beta_reg[BG_W-1]
                   && !b_gamma_reg[BG_W-1] && (bg_sum <= BG_ONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.hit          <= hit_next;
        result_reg.hit_distance <= hit_next ? b_t_reg : '0;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `RTI_ASSERT(a_done_follows_start, done |-> $past(start && !busy, LATENCY), "result without a ray")
    `RTI_ASSERT(a_miss_zero, (done && !result.hit) |-> (result.hit_distance == '0), "miss with distance")
    `RTI_ASSERT_NEXT(a_reject_miss, b_vld_reg && (b_zero_reg || !b_ivok_reg), done && !result.hit, "rejected ray reported as hit")

endmodule

// ----- tb/testbench.sv -----
// ============================================================================
// Ray-triangle intersection core testbench
// Sends rays through the core under several triangle setups and sender idle
// patterns. Each result is checked against an in-line fixed-point model of the
// projection test, or against a hand-written value for the simple directed
// rays.
// ============================================================================
`timescale 1ns / 1ps

module testbench;

    // PIPE_DEPTH matches the depth of the core's pipeline, so waiting a little
    // longer than that is enough to drain the pipeline at the end of the run.
    localparam int PIPE_DEPTH     = 42;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_COUNT    = 8;
    localparam int RAYS_PER_PHASE = 194;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    rti_pkg::ray_t ray;
    logic          done;
    rti_pkg::hit_t result;
    logic          cfg_we;
    logic [rti_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [rti_pkg::CFG_W-1:0]      cfg_wdata;

    // A directed row may carry its own answer; it travels with the ray.
    logic          row_known;
    rti_pkg::hit_t row_answer;

    ray_triangle_intersect_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .ray       (ray),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Shadow copy of the triangle registers, updated on every write.
    logic [1:0]  tri_axis;
    logic [63:0] tri_slopes;
    logic [31:0] tri_offset;
    logic [63:0] tri_beta;
    logic [63:0] tri_gamma;
    logic [63:0] tri_anchor;

    rti_pkg::hit_t pending_hits[$];
    int   error_count;
    int   quiet_cycles;

    function automatic longint half_q(logic [63:0] r, bit upper);
        return upper ? longint'($signed(r[63:32])) : longint'($signed(r[31:0]));
    endfunction

    // Q16.16 product, rounded toward minus infinity.
    function automatic longint mul_q(longint a, longint b);
        return (a * b) >>> rti_pkg::FRAC_BITS;
    endfunction

    function automatic longint clamp_q(longint x);
        if (x > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return x;
    endfunction

    // Division rounded toward zero to Q16.16, saturated on overflow.
    function automatic longint div_q(longint num, longint den);
        bit              neg;
        longint unsigned a;
        longint unsigned b;
        longint unsigned q;
        longint unsigned r;
        neg = (num < 0) != (den < 0);
        a = (num < 0) ? -num : num;
        b = (den < 0) ? -den : den;
        q = a / b;
        r = a % b;
        if (q >= (64'd1 << (31 - rti_pkg::FRAC_BITS))) begin
            return neg ? -64'sd2147483648 : 64'sd2147483647;
        end
        for (int i = 0; i < rti_pkg::FRAC_BITS; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= b) begin
                r = r - b;
                q = q | 64'd1;
            end
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic rti_pkg::hit_t intersect_ray(rti_pkg::ray_t r);
        longint o[3];
        longint d[3];
        longint su;
        longint sv;
        longint den;
        longint num;
        longint t;
        longint pu;
        longint pv;
        longint beta;
        longint gamma;
        int     n;
        int     u;
        int     v;
        rti_pkg::hit_t h;
        o[0] = longint'($signed(r.origin_x));
        o[1] = longint'($signed(r.origin_y));
        o[2] = longint'($signed(r.origin_z));
        d[0] = longint'($signed(r.dir_x));
        d[1] = longint'($signed(r.dir_y));
        d[2] = longint'($signed(r.dir_z));
        // The spare axis code behaves like x.
        n = (tri_axis == 2'd3) ? 0 : int'(tri_axis);
        u = (n + 1) % 3;
        v = (n + 2) % 3;
        su = half_q(tri_slopes, 0);
        sv = half_q(tri_slopes, 1);
        h = '0;
        den = d[n] + mul_q(su, d[u]) + mul_q(sv, d[v]);
        if (den == 0) begin
            return h;
        end
        num = longint'($signed(tri_offset)) - (o[n] + mul_q(su, o[u]) + mul_q(sv, o[v]));
        t = div_q(num, den);
        if (t < longint'($signed(r.t_min)) || t > longint'($signed(r.t_max))) begin
            return h;
        end
        pu = clamp_q(o[u] + mul_q(t, d[u]) - half_q(tri_anchor, 0));
        pv = clamp_q(o[v] + mul_q(t, d[v]) - half_q(tri_anchor, 1));
        beta = mul_q(pv, half_q(tri_beta, 0)) + mul_q(pu, half_q(tri_beta, 1));
        if (beta < 0) begin
            return h;
        end
        gamma = mul_q(pu, half_q(tri_gamma, 0)) + mul_q(pv, half_q(tri_gamma, 1));
        if (gamma < 0 || gamma + beta > rti_pkg::ONE_Q) begin
            return h;
        end
        h.hit = 1'b1;
        h.hit_distance = t[31:0];
        return h;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    // Every sampled handshake is handled here: register writes update the
    // shadow copy, accepted rays queue their expected hit, and each done
    // cycle is compared with the oldest expectation.
    always @(posedge clk)
    begin
        rti_pkg::hit_t want;
        if (rst_n) begin
            if (cfg_we) begin
                case (rti_pkg::cfg_reg_t'(cfg_addr))
                    rti_pkg::CFG_AXIS:   tri_axis   <= cfg_wdata[1:0];
                    rti_pkg::CFG_SLOPES: tri_slopes <= cfg_wdata;
                    rti_pkg::CFG_OFFSET: tri_offset <= cfg_wdata[31:0];
                    rti_pkg::CFG_BETA:   tri_beta   <= cfg_wdata;
                    rti_pkg::CFG_GAMMA:  tri_gamma  <= cfg_wdata;
                    rti_pkg::CFG_ANCHOR: tri_anchor <= cfg_wdata;
                    default: ;
                endcase
            end
            if (start && !busy) begin
                pending_hits.push_back(row_known ? row_answer : intersect_ray(ray));
            end
            if (done) begin
                if (pending_hits.size() == 0) begin
                    report_mismatch("unexpected transaction", {31'd0, result.hit}, 32'd0);
                end
                else begin
                    want = pending_hits.pop_front();
                    if (result.hit !== want.hit) begin
                        report_mismatch("hit", {31'd0, result.hit}, {31'd0, want.hit});
                    end
                    if (result.hit_distance !== want.hit_distance) begin
                        report_mismatch("hit_distance", result.hit_distance,
                                        want.hit_distance);
                    end
                end
            end
            quiet_cycles <= ((start && !busy) || done) ? 0 : quiet_cycles + 1;
        end
    end

    // A stuck handshake or a lost result stops the run.
    always @(posedge clk)
    begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Holds start high until the core takes the ray. Start stays high on
    // return so that back-to-back rays need no gap.
    task automatic send_ray(rti_pkg::ray_t r, bit known, rti_pkg::hit_t answer);
        ray        <= r;
        row_known  <= known;
        row_answer <= answer;
        start      <= 1'b1;
        do begin
            @(posedge clk);
        end while (busy);
    endtask

    // Leaves the write enable high; the caller drops it after its last write.
    task automatic write_reg(rti_pkg::cfg_reg_t index, logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= index;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    task automatic drain_pipeline();
        start <= 1'b0;
        while (pending_hits.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [31:0] near_q(int span);
        return 32'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic logic [63:0] near_pair(int span);
        return {near_q(span), near_q(span)};
    endfunction

    // Loads a whole triangle. Mode 1 pushes every register to all ones, mode 2
    // picks the z axis and the largest positive halves (upper anchor half most
    // negative), anything else a plausible triangle that a fair share of rays hits.
    task automatic load_triangle(int mode);
        if (mode == 1) begin
            write_reg(rti_pkg::CFG_AXIS, '1);
            write_reg(rti_pkg::CFG_SLOPES, '1);
            write_reg(rti_pkg::CFG_OFFSET, '1);
            write_reg(rti_pkg::CFG_BETA, '1);
            write_reg(rti_pkg::CFG_GAMMA, '1);
            write_reg(rti_pkg::CFG_ANCHOR, '1);
        end
        else if (mode == 2) begin
            write_reg(rti_pkg::CFG_AXIS, 64'(rti_pkg::AXIS_Z));
            write_reg(rti_pkg::CFG_SLOPES, {2{rti_pkg::Q_MAX}});
            write_reg(rti_pkg::CFG_OFFSET, 64'(rti_pkg::Q_MAX));
            write_reg(rti_pkg::CFG_BETA, {2{rti_pkg::Q_MAX}});
            write_reg(rti_pkg::CFG_GAMMA, {2{rti_pkg::Q_MAX}});
            write_reg(rti_pkg::CFG_ANCHOR, {rti_pkg::Q_MIN, rti_pkg::Q_MAX});
        end
        else begin
            write_reg(rti_pkg::CFG_AXIS, 64'($urandom_range(0, 3)));
            write_reg(rti_pkg::CFG_SLOPES, near_pair(1 << 16));
            write_reg(rti_pkg::CFG_OFFSET, 64'(near_q(8 << 16)));
            write_reg(rti_pkg::CFG_BETA, near_pair(1 << 15));
            write_reg(rti_pkg::CFG_GAMMA, near_pair(1 << 15));
            write_reg(rti_pkg::CFG_ANCHOR, near_pair(4 << 16));
        end
        cfg_we <= 1'b0;
    endtask

    function automatic rti_pkg::ray_t random_ray();
        rti_pkg::ray_t r;
        if ($urandom_range(0, 99) < 25) begin
            // Raw bits reach every field extreme and the saturation paths.
            r = {$urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom};
        end
        else begin
            r.origin_x = near_q(16 << 16);
            r.origin_y = near_q(16 << 16);
            r.origin_z = near_q(16 << 16);
            r.dir_x    = near_q(2 << 16);
            r.dir_y    = near_q(2 << 16);
            r.dir_z    = near_q(2 << 16);
            r.t_min    = ($urandom_range(0, 3) == 0) ? near_q(4 << 16) : '0;
            r.t_max    = ($urandom_range(0, 3) == 0) ? near_q(64 << 16) : rti_pkg::Q_MAX;
        end
        return r;
    endfunction

    typedef struct {
        rti_pkg::ray_t r;
        bit            known;
        rti_pkg::hit_t answer;
    } ray_row_t;

    // Directed rays, sent with the triangle registers still at reset. With
    // zero registers the plane is x = 0 and every in-interval t is a hit.
    localparam logic [31:0] Q_ONE = 32'h0001_0000;
    localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;
    localparam logic [31:0] QMX = rti_pkg::Q_MAX;
    localparam logic [31:0] QMN = rti_pkg::Q_MIN;
    ray_row_t directed_rays[] = '{
        // Parallel ray: a zero direction along x is a miss.
        '{'{'0, '0, '0, '0, Q_ONE, Q_ONE, '0, QMX}, 1'b1, '{1'b0, '0}},
        // Plain hit one unit along the ray.
        '{'{Q_NEG_ONE, '0, '0, Q_ONE, '0, '0, '0, 32'h0002_0000}, 1'b1,
          '{1'b1, Q_ONE}},
        // Empty interval gives a miss.
        '{'{Q_NEG_ONE, '0, '0, Q_ONE, '0, '0, 32'h0002_0000, Q_ONE}, 1'b1,
          '{1'b0, '0}},
        // Distance overflow saturates and still hits inside the interval.
        '{'{QMN, '0, '0, 32'h1, '0, '0, '0, QMX}, 1'b1, '{1'b1, QMX}},
        // Negative saturation falls below t_min.
        '{'{QMX, '0, '0, 32'h1, '0, '0, '0, QMX}, 1'b1, '{1'b0, '0}},
        '{'{QMN, QMN, QMN, QMN, QMN, QMN, QMN, QMN}, 1'b0, '0},
        '{'{QMX, QMX, QMX, QMX, QMX, QMX, QMX, QMX}, 1'b0, '0},
        '{'{'1, '1, '1, '1, '1, '1, '1, '1}, 1'b0, '0},
        '{'{Q_ONE, '0, '0, Q_NEG_ONE, '0, '0, Q_ONE, Q_ONE}, 1'b0, '0},
        '{'{Q_ONE, '0, '0, Q_NEG_ONE, QMX, QMN, '0, QMX}, 1'b0, '0},
        '{'{'0, '0, '0, QMN, '0, '0, QMN, QMX}, 1'b0, '0}
    };

    // Chance, in percent, that the sender idles once more before a ray; each
    // phase has its own share of idle cycles.
    int idle_pct[PHASE_COUNT] = '{0, 80, 16, 0, 80, 16, 0, 50};

    initial
    begin
        rst_n      <= 1'b0;
        start      <= 1'b0;
        ray        <= '0;
        row_known  <= 1'b0;
        row_answer <= '0;
        cfg_we     <= 1'b0;
        cfg_addr   <= '0;
        cfg_wdata  <= '0;
        tri_axis   = '0;
        tri_slopes = '0;
        tri_offset = '0;
        tri_beta   = '0;
        tri_gamma  = '0;
        tri_anchor = '0;
        error_count  = 0;
        quiet_cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rays[i]) begin
            send_ray(directed_rays[i].r, directed_rays[i].known, directed_rays[i].answer);
        end
        drain_pipeline();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            load_triangle(phase == 1 ? 1 : (phase == PHASE_COUNT - 1 ? 2 : 0));
            for (int k = 0; k < RAYS_PER_PHASE; k++) begin
                // Let the pipeline empty completely once, mid-phase.
                if (phase == 2 && k == RAYS_PER_PHASE / 2) begin
                    drain_pipeline();
                end
                else begin
                    while ($urandom_range(0, 99) < idle_pct[phase]) begin
                        start <= 1'b0;
                        @(posedge clk);
                    end
                end
                send_ray(random_ray(), 1'b0, '0);
            end
            drain_pipeline();
        end

        repeat (PIPE_DEPTH + 10) @(posedge clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end
        else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
